// ----- design/gdbo_pkg.sv -----
// Shared types and constants for the graph traversal block.
// No dependencies; every other file refers to it by scoped names.
package gdbo_pkg;

  localparam int VERT_W       = 5;
  localparam int MAX_VERTICES = 1 << VERT_W;
  localparam int CNT_W        = VERT_W + 1;

  typedef logic [VERT_W-1:0]       vertex_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [MAX_VERTICES-1:0] vset_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_DFS   = 2'd2,
    MODE_BFS   = 2'd3
  } mode_e;

endpackage

// ----- design/gdbo_req_if.sv -----
// Request channel of the graph traversal block: valid/ready plus payload.
// Depends on gdbo_pkg.
interface gdbo_req_if;
  logic             valid;
  logic             ready;
  gdbo_pkg::mode_e  mode;
  gdbo_pkg::vertex_t first_vertex;
  gdbo_pkg::vertex_t second_vertex;

  modport source (output valid, mode, first_vertex, second_vertex, input ready);
  modport sink   (input valid, mode, first_vertex, second_vertex, output ready);
endinterface

// ----- design/gdbo_res_if.sv -----
// Result channel of the graph traversal block: valid/ready plus payload.
// Depends on gdbo_pkg.
interface gdbo_res_if;
  logic              valid;
  logic              ready;
  gdbo_pkg::vertex_t visited_vertex;
  logic              last;

  modport source (output valid, visited_vertex, last, input ready);
  modport sink   (input valid, visited_vertex, last, output ready);
endinterface

// ----- design/gdbo_lowbit.sv -----
// Shared neighbor picker: finds the lowest set bit of a candidate vertex set.
// Depends on gdbo_pkg.
module gdbo_lowbit (
  input  gdbo_pkg::vset_t   cand_i,
  output logic              found_o,
  output gdbo_pkg::vertex_t idx_o
);

  always_comb begin
    idx_o = '0;
    // scan from the top so the lowest set bit wins
    for (int i = gdbo_pkg::MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand_i[i]) begin
        idx_o = gdbo_pkg::vertex_t'(i);
      end
    end
  end

  assign found_o = |cand_i;

endmodule

// ----- design/graph_dfs_bfs_order.sv -----
// Graph traversal block: adjacency matrix, visit sequencer, stack/queue store.
// Depends on gdbo_pkg, gdbo_req_if, gdbo_res_if and gdbo_lowbit.
//
// Usage:
//   req_i carries one request: mode (add edge, clear, depth-first run,
//   breadth-first run), first_vertex and second_vertex. It is taken when
//   valid and ready are both high; ready is high only while the sequencer
//   is idle, so one request is worked on at a time.
//   res_o carries the visit order of a run, one vertex per transfer, with
//   last set on the final vertex. Add-edge and clear give no results.
// Add edge sets the bit in the first vertex's row, then the mirror bit in the
// second vertex's row; clear empties the matrix and the visited set.
// A depth-first run either pushes a new neighbor, emitting the pending vertex,
// or pops a finished vertex; with the stack empty it emits the final vertex.
// A breadth-first run loads each dequeued vertex, enqueues its newly found
// neighbors, then emits that vertex.
// Each neighbor search uses the one lowest-bit picker, which sets the pace.
// Reset clears the matrix, the visited set and the output valid flag.
// A stalled receiver holds the output register; the sequencer's emit steps wait on it.
module graph_dfs_bfs_order (
  input  logic              clk_i,
  input  logic              rst_ni,
  gdbo_req_if.sink          req_i,
  gdbo_res_if.source        res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD2,
    ST_DFS,
    ST_DFS_LAST,
    ST_BFS_LOAD,
    ST_BFS_SCAN
  } state_e;

  localparam gdbo_pkg::cnt_t CNT_ONE = gdbo_pkg::cnt_t'(1);

  state_e            state_q, state_d;
  gdbo_pkg::vset_t   visited_q, visited_d;
  gdbo_pkg::cnt_t    top_q, top_d;       // stack depth, also queue tail
  gdbo_pkg::cnt_t    head_q, head_d;
  gdbo_pkg::vertex_t cur_q, cur_d;       // pending DFS vertex / current BFS vertex
  gdbo_pkg::vertex_t edge_a_q, edge_a_d;
  gdbo_pkg::vertex_t edge_b_q, edge_b_d;
  logic              res_valid_q, res_valid_d;
  gdbo_pkg::vertex_t res_vertex_q, res_vertex_d;
  logic              res_last_q, res_last_d;

  gdbo_pkg::vset_t   adj_q [gdbo_pkg::MAX_VERTICES];
  gdbo_pkg::vertex_t walk_mem [gdbo_pkg::MAX_VERTICES];

  logic              adj_set;
  logic              adj_clear;
  gdbo_pkg::vertex_t adj_row;
  gdbo_pkg::vertex_t adj_col;
  logic              mem_we;
  gdbo_pkg::vertex_t mem_waddr;
  gdbo_pkg::vertex_t mem_wdata;

  gdbo_pkg::cnt_t    top_dec;
  gdbo_pkg::vertex_t rd_addr;
  gdbo_pkg::vertex_t rd_data;
  gdbo_pkg::vertex_t row_sel;
  gdbo_pkg::vset_t   cand;
  logic              pick_found;
  gdbo_pkg::vertex_t pick_idx;
  logic              out_free;
  logic              req_fire;

  assign top_dec  = top_q - CNT_ONE;
  assign rd_addr  = (state_q == ST_DFS) ? top_dec[gdbo_pkg::VERT_W-1:0]
                                        : head_q[gdbo_pkg::VERT_W-1:0];
  assign rd_data  = walk_mem[rd_addr];
  assign row_sel  = (state_q == ST_DFS) ? rd_data : cur_q;
  assign cand     = adj_q[row_sel] & ~visited_q;
  assign out_free = !res_valid_q || res_o.ready;
  assign req_fire = req_i.valid && req_i.ready;

  gdbo_lowbit u_lowbit (
    .cand_i  (cand),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  assign req_i.ready          = (state_q == ST_IDLE);
  assign res_o.valid          = res_valid_q;
  assign res_o.visited_vertex = res_vertex_q;
  assign res_o.last           = res_last_q;

  always_comb begin
    state_d      = state_q;
    visited_d    = visited_q;
    top_d        = top_q;
    head_d       = head_q;
    cur_d        = cur_q;
    edge_a_d     = edge_a_q;
    edge_b_d     = edge_b_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_vertex_d = res_vertex_q;
    res_last_d   = res_last_q;
    adj_set      = 1'b0;
    adj_clear    = 1'b0;
    adj_row      = edge_b_q;
    adj_col      = edge_a_q;
    mem_we       = 1'b0;
    mem_waddr    = top_q[gdbo_pkg::VERT_W-1:0];
    mem_wdata    = pick_idx;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.mode)
            gdbo_pkg::MODE_ADD: begin
              adj_set  = 1'b1;
              adj_row  = req_i.first_vertex;
              adj_col  = req_i.second_vertex;
              edge_a_d = req_i.first_vertex;
              edge_b_d = req_i.second_vertex;
              state_d  = ST_ADD2;
            end
            gdbo_pkg::MODE_CLEAR: begin
              adj_clear = 1'b1;
              visited_d = '0;
            end
            gdbo_pkg::MODE_DFS: begin
              visited_d = gdbo_pkg::vset_t'(1) << req_i.first_vertex;
              cur_d     = req_i.first_vertex;
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = req_i.first_vertex;
              top_d     = CNT_ONE;
              state_d   = ST_DFS;
            end
            gdbo_pkg::MODE_BFS: begin
              visited_d = gdbo_pkg::vset_t'(1) << req_i.first_vertex;
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = req_i.first_vertex;
              top_d     = CNT_ONE;
              head_d    = '0;
              state_d   = ST_BFS_LOAD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_ADD2: begin
        // mirror bit of the undirected edge
        adj_set = 1'b1;
        state_d = ST_IDLE;
      end

      ST_DFS: begin
        if (!pick_found) begin
          // drop a finished vertex from the stack
          top_d = top_dec;
          if (top_q == CNT_ONE) begin
            state_d = ST_DFS_LAST;
          end
        end else if (out_free) begin
          // a new vertex follows, so the pending one is not last
          res_valid_d  = 1'b1;
          res_vertex_d = cur_q;
          res_last_d   = 1'b0;
          cur_d        = pick_idx;
          visited_d    = visited_q | (gdbo_pkg::vset_t'(1) << pick_idx);
          mem_we       = 1'b1;
          top_d        = top_q + CNT_ONE;
        end
      end

      ST_DFS_LAST: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_vertex_d = cur_q;
          res_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_BFS_LOAD: begin
        cur_d   = rd_data;
        head_d  = head_q + CNT_ONE;
        state_d = ST_BFS_SCAN;
      end

      ST_BFS_SCAN: begin
        if (pick_found) begin
          // enqueue the next unvisited neighbor
          visited_d = visited_q | (gdbo_pkg::vset_t'(1) << pick_idx);
          mem_we    = 1'b1;
          top_d     = top_q + CNT_ONE;
        end else if (out_free) begin
          res_valid_d  = 1'b1;
          res_vertex_d = cur_q;
          res_last_d   = (head_q == top_q);
          state_d      = (head_q == top_q) ? ST_IDLE : ST_BFS_LOAD;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      visited_q   <= '0;
      top_q       <= '0;
      head_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      top_q       <= top_d;
      head_q      <= head_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    edge_a_q     <= edge_a_d;
    edge_b_q     <= edge_b_d;
    res_vertex_q <= res_vertex_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < gdbo_pkg::MAX_VERTICES; r++) begin
        adj_q[r] <= '0;
      end
    end else if (adj_clear) begin
      for (int r = 0; r < gdbo_pkg::MAX_VERTICES; r++) begin
        adj_q[r] <= '0;
      end
    end else if (adj_set) begin
      adj_q[adj_row][adj_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      walk_mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for graph_dfs_bfs_order: directed table, then random graphs.
// Depends on gdbo_pkg, gdbo_req_if, gdbo_res_if and the block itself.
// An in-bench traversal predictor supplies the visit order checked on res_o.
module tb_top;

  localparam int ITEM_TARGET = 170;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 120;

  typedef struct {
    gdbo_pkg::vertex_t vertex;
    logic              last;
  } visit_t;

  typedef struct {
    gdbo_pkg::mode_e   mode;
    gdbo_pkg::vertex_t first_v;
    gdbo_pkg::vertex_t second_v;
    bit                typed;
    gdbo_pkg::vertex_t typed_v;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  gdbo_req_if req ();
  gdbo_res_if res ();

  graph_dfs_bfs_order uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  // Mirror of the graph and the expected visit order.
  gdbo_pkg::vset_t adj_rows [gdbo_pkg::MAX_VERTICES];
  gdbo_pkg::vset_t seen_set;
  visit_t          visit_q [$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  runs_sent    = 0;
  int  visits_seen  = 0;
  int  longest_run  = 0;
  int  quiet_cycles = 0;
  bit  idle_on      = 1'b1;
  bit  hold_long    = 1'b0;

  dir_row_t dir_rows [24] = '{
    '{gdbo_pkg::MODE_DFS,   5'd0,  5'd0,  1'b1, 5'd0},
    '{gdbo_pkg::MODE_BFS,   5'd31, 5'd0,  1'b1, 5'd31},
    '{gdbo_pkg::MODE_ADD,   5'd0,  5'd31, 1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd31, 5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd5,  5'd5,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd5,  5'd0,  1'b1, 5'd5},
    '{gdbo_pkg::MODE_BFS,   5'd5,  5'd31, 1'b1, 5'd5},
    '{gdbo_pkg::MODE_ADD,   5'd0,  5'd1,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd1,  5'd2,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd0,  5'd3,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd2,  5'd4,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd3,  5'd4,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd31, 5'd30, 1'b0, 5'd0},
    '{gdbo_pkg::MODE_ADD,   5'd10, 5'd21, 1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd0,  5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_BFS,   5'd0,  5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd31, 5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_BFS,   5'd4,  5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd21, 5'd0,  1'b0, 5'd0},
    '{gdbo_pkg::MODE_CLEAR, 5'd31, 5'd31, 1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd0,  5'd0,  1'b1, 5'd0},
    '{gdbo_pkg::MODE_BFS,   5'd31, 5'd0,  1'b1, 5'd31},
    '{gdbo_pkg::MODE_ADD,   5'd31, 5'd31, 1'b0, 5'd0},
    '{gdbo_pkg::MODE_DFS,   5'd31, 5'd0,  1'b1, 5'd31}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_order(const ref gdbo_pkg::vertex_t order [$]);
    visit_t item;
    for (int i = 0; i < order.size(); i++) begin
      item.vertex = order[i];
      item.last   = (i == order.size() - 1);
      visit_q     = {visit_q, item};
    end
    if (order.size() > longest_run) longest_run = order.size();
  endfunction

  function automatic void predict_depth_first(gdbo_pkg::vertex_t start);
    gdbo_pkg::vertex_t stack [$];
    gdbo_pkg::vertex_t order [$];
    gdbo_pkg::vertex_t top_v;
    gdbo_pkg::vset_t   cand;
    int                pick;
    seen_set        = '0;
    seen_set[start] = 1'b1;
    order           = {order, start};
    stack           = {stack, start};
    while (stack.size() > 0) begin
      top_v = stack[stack.size() - 1];
      cand  = adj_rows[top_v] & ~seen_set;
      if (cand == '0) begin
        void'(stack.pop_back());
      end else begin
        pick = 0;
        for (int i = gdbo_pkg::MAX_VERTICES - 1; i >= 0; i--) if (cand[i]) pick = i;
        seen_set[pick] = 1'b1;
        order = {order, gdbo_pkg::vertex_t'(pick)};
        stack = {stack, gdbo_pkg::vertex_t'(pick)};
      end
    end
    queue_order(order);
  endfunction

  function automatic void predict_breadth_first(gdbo_pkg::vertex_t start);
    gdbo_pkg::vertex_t frontier [$];
    gdbo_pkg::vertex_t order [$];
    gdbo_pkg::vertex_t cur;
    gdbo_pkg::vset_t   cand;
    seen_set        = '0;
    seen_set[start] = 1'b1;
    frontier        = {frontier, start};
    while (frontier.size() > 0) begin
      cur   = frontier.pop_front();
      cand  = adj_rows[cur] & ~seen_set;
      order = {order, cur};
      for (int i = 0; i < gdbo_pkg::MAX_VERTICES; i++) begin
        if (cand[i]) begin
          seen_set[i] = 1'b1;
          frontier    = {frontier, gdbo_pkg::vertex_t'(i)};
        end
      end
    end
    queue_order(order);
  endfunction

  function automatic void apply_request(gdbo_pkg::mode_e mode, gdbo_pkg::vertex_t a,
                                        gdbo_pkg::vertex_t b);
    case (mode)
      gdbo_pkg::MODE_ADD: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      gdbo_pkg::MODE_CLEAR: begin
        for (int i = 0; i < gdbo_pkg::MAX_VERTICES; i++) adj_rows[i] = '0;
        seen_set = '0;
      end
      gdbo_pkg::MODE_DFS: predict_depth_first(a);
      default:            predict_breadth_first(a);
    endcase
  endfunction

  // Offer one request and wait for it to be taken; typed rows bypass the predictor.
  task automatic send_request(gdbo_pkg::mode_e mode, gdbo_pkg::vertex_t a,
                              gdbo_pkg::vertex_t b, bit typed = 1'b0,
                              gdbo_pkg::vertex_t typed_v = '0);
    int     gap;
    visit_t item;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid         <= 1'b1;
    req.mode          <= mode;
    req.first_vertex  <= a;
    req.second_vertex <= b;
    do @(posedge clk_i); while (!req.ready);
    items_sent++;
    if (mode == gdbo_pkg::MODE_DFS || mode == gdbo_pkg::MODE_BFS) runs_sent++;
    if (typed) begin
      item.vertex = typed_v;
      item.last   = 1'b1;
      visit_q     = {visit_q, item};
    end else begin
      apply_request(mode, a, b);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_long = 1'b0;
        res.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    visit_t want;
    if (res.valid && res.ready) begin
      visits_seen++;
      if (visit_q.size() == 0) begin
        mismatches++;
        $error("unexpected result: visited_vertex=%0d last=%0b",
               res.visited_vertex, res.last);
      end else begin
        want = visit_q.pop_front();
        if (res.visited_vertex !== want.vertex) begin
          mismatches++;
          $error("visited_vertex: expected %0d, actual %0d", want.vertex, res.visited_vertex);
        end
        if (res.last !== want.last) begin
          mismatches++;
          $error("last: expected %0b, actual %0b", want.last, res.last);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("graph_dfs_bfs_order: mismatch");
        $finish;
      end
    end
  end

  initial begin
    gdbo_pkg::vertex_t perm [gdbo_pkg::MAX_VERTICES];
    gdbo_pkg::vertex_t tmp;
    int                j;
    int                span;
    gdbo_pkg::mode_e   run_mode;

    rst_ni            = 1'b0;
    req.valid         = 1'b0;
    req.mode          = gdbo_pkg::MODE_ADD;
    req.first_vertex  = '0;
    req.second_vertex = '0;
    for (int i = 0; i < gdbo_pkg::MAX_VERTICES; i++) adj_rows[i] = '0;
    seen_set = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].mode, dir_rows[i].first_v, dir_rows[i].second_v,
                   dir_rows[i].typed, dir_rows[i].typed_v);

    // One random spanning path over all vertices: runs of the full length.
    send_request(gdbo_pkg::MODE_CLEAR, gdbo_pkg::vertex_t'($urandom_range(0, 31)),
                 gdbo_pkg::vertex_t'($urandom_range(0, 31)));
    for (int i = 0; i < gdbo_pkg::MAX_VERTICES; i++) perm[i] = gdbo_pkg::vertex_t'(i);
    for (int i = gdbo_pkg::MAX_VERTICES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < gdbo_pkg::MAX_VERTICES - 1; i++)
      send_request(gdbo_pkg::MODE_ADD, perm[i], perm[i + 1]);
    // Hold the receiver while runs keep coming so the block backs up.
    hold_long = 1'b1;
    send_request(gdbo_pkg::MODE_DFS, gdbo_pkg::vertex_t'($urandom_range(0, 31)), '0);
    send_request(gdbo_pkg::MODE_BFS, gdbo_pkg::vertex_t'($urandom_range(0, 31)), '0);
    send_request(gdbo_pkg::MODE_DFS, perm[0], '0);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - 30) idle_on = 1'b0;
      if ($urandom_range(0, 4) == 0)
        send_request(gdbo_pkg::MODE_CLEAR, gdbo_pkg::vertex_t'($urandom),
                     gdbo_pkg::vertex_t'($urandom));
      span = ($urandom_range(0, 3) == 0) ? 31 : 7;
      repeat ($urandom_range(1, 8))
        send_request(gdbo_pkg::MODE_ADD, gdbo_pkg::vertex_t'($urandom_range(0, span)),
                     gdbo_pkg::vertex_t'($urandom_range(0, span)));
      repeat ($urandom_range(1, 3)) begin
        run_mode = ($urandom_range(0, 1) == 0) ? gdbo_pkg::MODE_DFS : gdbo_pkg::MODE_BFS;
        send_request(run_mode, gdbo_pkg::vertex_t'($urandom_range(0, span)),
                     gdbo_pkg::vertex_t'($urandom));
      end
      if ($urandom_range(0, 5) == 0)
        send_request(gdbo_pkg::mode_e'($urandom_range(0, 3)), gdbo_pkg::vertex_t'($urandom),
                     gdbo_pkg::vertex_t'($urandom));
    end

    @(negedge clk_i);
    req.valid <= 1'b0;
    while (visit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d requests, %0d traversal runs, %0d visits checked",
             items_sent, runs_sent, visits_seen);
    $display("longest run %0d vertices, mismatches %0d", longest_run, mismatches);
    if (mismatches == 0 && visit_q.size() == 0) begin
      $display("graph_dfs_bfs_order: match");
    end else begin
      $display("graph_dfs_bfs_order: mismatch");
    end
    $finish;
  end

endmodule
